// ===== hw/rtl/lbt_pkg.sv =====
// ----------------------------------------------------------------------------
// lbt_pkg: light balance tilt tracker shared types and constants
// Field widths, register indexes, reset values, servo scaling constants and
// the request and response records of the shared divider.
// ----------------------------------------------------------------------------
package lbt_pkg;

    localparam int LIGHT_W  = 17;
    localparam int SUM_W    = 18;
    localparam int POS_W    = 18;
    localparam int PWM_W    = 12;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = 28;
    localparam int DIV_W    = 26;
    localparam int DEN_W    = 18;
    localparam int CNT_W    = 5;
    localparam int PULSE_W  = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER     = 2'd2;

    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 10'd800;
    localparam logic [CFG_W-1:0] LOWER_RESET     = 10'd495;
    localparam logic [CFG_W-1:0] UPPER_RESET     = 10'd765;
    localparam logic [POS_W-1:0] TILT_RESET      = 18'd153600;

    localparam logic [PROD_W-1:0] PERMILLE = 28'd1000;

    // pulse_us = 500 + pos * 25 / 576, pwm = pulse * 128 / 625
    localparam logic [4:0]         PWM_SCALE     = 5'd25;
    localparam logic [DEN_W-1:0]   PWM_DEN_POS   = 18'd576;
    localparam logic [DEN_W-1:0]   PWM_DEN_PULSE = 18'd625;
    localparam logic [PULSE_W-1:0] PULSE_MIN_US  = 14'd500;
    localparam logic [CNT_W-1:0]   STEP_BITS     = 5'd26;
    localparam logic [CNT_W-1:0]   POS_Q_BITS    = 5'd14;
    localparam logic [CNT_W-1:0]   PULSE_Q_BITS  = 5'd12;

    typedef enum logic [1:0] {
        MOVE_HOLD = 2'd0,
        MOVE_DOWN = 2'd1,
        MOVE_UP   = 2'd2
    } t_move;

    typedef struct packed {
        logic [CFG_W-1:0] threshold;
        logic [CFG_W-1:0] lower;
        logic [CFG_W-1:0] upper;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] rem0;
        logic [DEN_W-1:0] den;
        logic [CNT_W-1:0] count;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== hw/rtl/lbt_ifs.sv =====
// ----------------------------------------------------------------------------
// lbt_ifs: light balance tilt tracker channel interfaces
// Valid/ready channels for light samples, results and register writes.
// ----------------------------------------------------------------------------
interface lbt_in_if;
    logic                          valid;
    logic                          ready;
    logic [lbt_pkg::LIGHT_W-1:0]   light_q0;
    logic [lbt_pkg::LIGHT_W-1:0]   light_q1;
    logic [lbt_pkg::LIGHT_W-1:0]   light_q2;
    logic [lbt_pkg::LIGHT_W-1:0]   light_q3;

    modport source (output valid, light_q0, light_q1, light_q2, light_q3, input ready);
    modport sink   (input valid, light_q0, light_q1, light_q2, light_q3, output ready);
endinterface

interface lbt_out_if;
    logic                        valid;
    logic                        ready;
    logic [lbt_pkg::POS_W-1:0]   position_q8;
    logic [lbt_pkg::PWM_W-1:0]   pwm_count;
    logic [1:0]                  move_kind;
    logic                        clamped;

    modport source (output valid, position_q8, pwm_count, move_kind, clamped, input ready);
    modport sink   (input valid, position_q8, pwm_count, move_kind, clamped, output ready);
endinterface

interface lbt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lbt_pkg::CFG_IDX_W-1:0]   index;
    logic [lbt_pkg::CFG_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/lbt_cfg.sv =====
// ----------------------------------------------------------------------------
// lbt_cfg: configuration registers
// Threshold and end stop registers, written through the register channel.
// ----------------------------------------------------------------------------
module lbt_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lbt_cfg_if.sink        i_cfg,
    output lbt_pkg::t_cfg  o_cfg
);

    lbt_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= lbt_pkg::THRESHOLD_RESET;
            r_cfg.lower     <= lbt_pkg::LOWER_RESET;
            r_cfg.upper     <= lbt_pkg::UPPER_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lbt_pkg::CFG_THRESHOLD: r_cfg.threshold <= i_cfg.data;
                lbt_pkg::CFG_LOWER:     r_cfg.lower     <= i_cfg.data;
                lbt_pkg::CFG_UPPER:     r_cfg.upper     <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/lbt_div.sv =====
// ----------------------------------------------------------------------------
// lbt_div: shared restoring divider
// One quotient bit per cycle; the caller supplies the starting remainder,
// the left-aligned dividend bits still to process and their count.
// ----------------------------------------------------------------------------
module lbt_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lbt_pkg::t_div_req  i_req,
    output lbt_pkg::t_div_rsp  o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [lbt_pkg::CNT_W-1:0]    r_cnt;
    logic [lbt_pkg::DEN_W-1:0]    r_rem;
    logic [lbt_pkg::DEN_W-1:0]    r_den;
    logic [lbt_pkg::DIV_W-1:0]    r_num;
    logic [lbt_pkg::DIV_W-1:0]    r_quot;

    logic [lbt_pkg::DEN_W+1:0]    w_trial;
    logic                         w_borrow;
    logic [lbt_pkg::DEN_W-1:0]    w_rem;

    always_comb begin
        w_trial  = {1'b0, r_rem, r_num[lbt_pkg::DIV_W-1]} - {2'b00, r_den};
        w_borrow = w_trial[lbt_pkg::DEN_W+1];
        w_rem    = w_borrow ? {r_rem[lbt_pkg::DEN_W-2:0], r_num[lbt_pkg::DIV_W-1]}
                            : w_trial[lbt_pkg::DEN_W-1:0];
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
                r_rem  <= i_req.rem0;
                r_den  <= i_req.den;
                r_num  <= i_req.num;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= w_rem;
                r_num  <= {r_num[lbt_pkg::DIV_W-2:0], 1'b0};
                r_quot <= {r_quot[lbt_pkg::DIV_W-2:0], ~w_borrow};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/light_balance_tilt_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// light_balance_tilt_tracker_unit: quadrant light balance tilt tracker
// Compares the two quadrant pair sums and steps, clamps or holds the tilt position, then
// converts the new position into a servo PWM off count.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   carries one sample of four quadrant light levels per item.
//   o_out  carries one result per item: position, PWM count, move, clamp.
//   i_cfg  writes threshold (0), lower limit (1) and upper limit (2); it is
//          always ready. It is to be written only while no item is in flight; the block itself does not enforce this.
// Timing:
//   An item runs through a sequencer around one shared restoring divider
//   and three multipliers. The step quotient is divided first when the move
//   needs one, then the PWM conversion runs two more divisions. The result
//   is then loaded into the output register, and i_in is ready again in
//   the cycle after the load, so a new item is accepted only once the
//   result of the previous one has been loaded.
// Reset:
//   Registers return to 800, 495 and 765; the tilt position to 600.0.
// Stall:
//   A result waits in the output register; the next item is accepted and
//   processed meanwhile, and its result waits until the slot is free.
// ----------------------------------------------------------------------------
module light_balance_tilt_tracker_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lbt_in_if.sink   i_in,
    lbt_out_if.source o_out,
    lbt_cfg_if.sink  i_cfg
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_B,
        S_CMP_B,
        S_CMP_A,
        S_DECIDE,
        S_STEP_DIV,
        S_APPLY,
        S_PWM1,
        S_PWM1_WAIT,
        S_PWM2,
        S_PWM2_WAIT,
        S_OUT
    } t_state;

    t_state                           r_state;
    lbt_pkg::t_cfg                    w_cfg;
    lbt_pkg::t_div_req                w_req;
    lbt_pkg::t_div_rsp                w_rsp;

    logic [lbt_pkg::SUM_W-1:0]        r_a;
    logic [lbt_pkg::SUM_W-1:0]        r_b;
    logic [lbt_pkg::PROD_W-1:0]       r_prod;
    logic                             r_dn;
    logic                             r_up;
    logic [lbt_pkg::POS_W-1:0]        r_pos;
    logic [lbt_pkg::DIV_W-1:0]        r_step;
    lbt_pkg::t_move                   r_kind;
    logic                             r_clamp;
    logic [lbt_pkg::PULSE_W-1:0]      r_pulse;
    logic [lbt_pkg::PWM_W-1:0]        r_pwm;

    logic                             r_out_valid;
    logic [lbt_pkg::POS_W-1:0]        r_out_pos;
    logic [lbt_pkg::PWM_W-1:0]        r_out_pwm;
    lbt_pkg::t_move                   r_out_kind;
    logic                             r_out_clamp;

    logic [lbt_pkg::SUM_W-1:0]        w_mul_in;
    logic [lbt_pkg::PROD_W-1:0]       w_prod;
    logic [lbt_pkg::SUM_W-1:0]        w_k_in;
    logic [lbt_pkg::PROD_W-1:0]       w_k1000;
    logic [lbt_pkg::POS_W-1:0]        w_lo;
    logic [lbt_pkg::POS_W-1:0]        w_hi;
    logic [lbt_pkg::POS_W+4:0]        w_x;
    logic [lbt_pkg::DIV_W:0]          w_sum;
    logic [lbt_pkg::POS_W-1:0]        w_diff;
    logic                             w_out_free;

    lbt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    lbt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_mul_in = (r_state == S_MUL_B) ? r_b : r_a;
        w_prod   = {10'd0, w_mul_in} * {18'd0, w_cfg.threshold};
        w_k_in   = (r_state == S_CMP_B) ? r_a : r_b;
        w_k1000  = {10'd0, w_k_in} * lbt_pkg::PERMILLE;
        w_lo     = {w_cfg.lower, 8'd0};
        w_hi     = {w_cfg.upper, 8'd0};
        w_x      = {5'd0, r_pos} * {18'd0, lbt_pkg::PWM_SCALE};
        w_sum    = {9'd0, r_pos} + {1'b0, r_step};
        w_diff   = r_pos - r_step[lbt_pkg::POS_W-1:0];
        w_out_free = !r_out_valid || o_out.ready;
    end

    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_DECIDE: begin
                w_req.rem0  = '0;
                w_req.count = lbt_pkg::STEP_BITS;
                if (r_dn) begin
                    w_req.start = (r_a != '0);
                    w_req.num   = {r_b, 8'd0};
                    w_req.den   = r_a;
                end else begin
                    w_req.start = r_up && (r_b != '0);
                    w_req.num   = {r_a, 8'd0};
                    w_req.den   = r_b;
                end
            end
            S_PWM1: begin
                w_req.start = 1'b1;
                w_req.rem0  = {9'd0, w_x[22:14]};
                w_req.num   = {w_x[13:0], 12'd0};
                w_req.den   = lbt_pkg::PWM_DEN_POS;
                w_req.count = lbt_pkg::POS_Q_BITS;
            end
            S_PWM2: begin
                w_req.start = 1'b1;
                w_req.rem0  = {9'd0, r_pulse[13:5]};
                w_req.num   = {r_pulse[4:0], 21'd0};
                w_req.den   = lbt_pkg::PWM_DEN_PULSE;
                w_req.count = lbt_pkg::PULSE_Q_BITS;
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.position_q8 = r_out_pos;
    assign o_out.pwm_count   = r_out_pwm;
    assign o_out.move_kind   = r_out_kind;
    assign o_out.clamped     = r_out_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= lbt_pkg::TILT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_a     <= {1'b0, i_in.light_q0} + {1'b0, i_in.light_q3};
                        r_b     <= {1'b0, i_in.light_q1} + {1'b0, i_in.light_q2};
                        r_state <= S_MUL_B;
                    end
                end
                S_MUL_B: begin
                    r_prod  <= w_prod;
                    r_state <= S_CMP_B;
                end
                S_CMP_B: begin
                    r_dn    <= (r_b != '0) && (w_k1000 < r_prod);
                    r_prod  <= w_prod;
                    r_state <= S_CMP_A;
                end
                S_CMP_A: begin
                    r_up    <= (r_a != '0) && (w_k1000 < r_prod);
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    priority if (r_dn) begin
                        r_kind <= lbt_pkg::MOVE_DOWN;
                        if (r_a == '0) begin
                            r_pos   <= w_lo;
                            r_clamp <= 1'b1;
                            r_state <= S_PWM1;
                        end else begin
                            r_clamp <= 1'b0;
                            r_state <= S_STEP_DIV;
                        end
                    end else if (r_up) begin
                        r_kind <= lbt_pkg::MOVE_UP;
                        if (r_b == '0) begin
                            r_pos   <= w_hi;
                            r_clamp <= 1'b1;
                            r_state <= S_PWM1;
                        end else begin
                            r_clamp <= 1'b0;
                            r_state <= S_STEP_DIV;
                        end
                    end else begin
                        r_kind  <= lbt_pkg::MOVE_HOLD;
                        r_clamp <= 1'b0;
                        r_state <= S_PWM1;
                    end
                end
                S_STEP_DIV: begin
                    if (w_rsp.done) begin
                        r_step  <= w_rsp.quot;
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (r_kind == lbt_pkg::MOVE_DOWN) begin
                        if ((r_step > {8'd0, r_pos}) || (w_diff < w_lo)) begin
                            r_pos   <= w_lo;
                            r_clamp <= 1'b1;
                        end else begin
                            r_pos <= w_diff;
                        end
                    end else begin
                        if (w_sum > {9'd0, w_hi}) begin
                            r_pos   <= w_hi;
                            r_clamp <= 1'b1;
                        end else begin
                            r_pos <= w_sum[lbt_pkg::POS_W-1:0];
                        end
                    end
                    r_state <= S_PWM1;
                end
                S_PWM1: begin
                    r_state <= S_PWM1_WAIT;
                end
                S_PWM1_WAIT: begin
                    if (w_rsp.done) begin
                        r_pulse <= lbt_pkg::PULSE_MIN_US + w_rsp.quot[lbt_pkg::PULSE_W-1:0];
                        r_state <= S_PWM2;
                    end
                end
                S_PWM2: begin
                    r_state <= S_PWM2_WAIT;
                end
                S_PWM2_WAIT: begin
                    if (w_rsp.done) begin
                        r_pwm   <= w_rsp.quot[lbt_pkg::PWM_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_pos   <= r_pos;
                        r_out_pwm   <= r_pwm;
                        r_out_kind  <= r_kind;
                        r_out_clamp <= r_clamp;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("divider started while busy");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready right after an accepted item");

    a_hold_not_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == lbt_pkg::MOVE_HOLD) |-> !r_out_clamp)
        else $error("hold result flagged as clamped");

    a_down_clamp_at_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clamp && r_out_kind == lbt_pkg::MOVE_DOWN)
        |-> (r_out_pos == w_lo))
        else $error("down clamp not at lower limit");

endmodule
